// ===== hdl/spba_pkg.sv =====
// Shared types, constants and a helper function of the power-of-two block allocator.
package spba_pkg;

	// Field widths of the request and response beats.
	localparam int CMD_W    = 2;
	localparam int SIZE_W   = 16;
	localparam int ADDR_W   = 16;
	localparam int CIDX_W   = 4;
	localparam int BYTES_W  = 17;
	localparam int CCOUNT_W = 14;
	localparam int LIVE_W   = 14;
	localparam int TOTAL_W  = 32;
	localparam int FREEB_W  = 17;
	localparam int CFG_W    = 17;

	// Header store geometry: one header per 8-byte slot.
	localparam int HDR_IDX_W   = 13;
	localparam int HDR_DEPTH   = 8192;
	localparam int HDR_BYTES   = 8;
	localparam int HDR_SHIFT   = 3;
	localparam int CNT_W       = 13;
	localparam int POW_W       = 5;

	// Heap size register value after reset.
	localparam logic [CFG_W-1:0] HEAP_SIZE_RST = 17'd65536;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SIZE  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_COUNT = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // latch the accepted request beat
		logic rd;      // read the header store
		logic commit;  // apply the operation and load the response register
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic rsp_stall;  // response register is full and not being taken
	} dp_stat_t;

	// Number of significant bits of a 16-bit value.
	function automatic logic [POW_W-1:0] bit_len16(input logic [SIZE_W-1:0] v);
		logic [POW_W-1:0] n;
		n = '0;
		for (int i = 0; i < SIZE_W; i++) begin
			if (v[i]) begin
				n = POW_W'(i + 1);
			end
		end
		return n;
	endfunction

endpackage

// ===== hdl/spba_if.sv =====
// Request and response channel interfaces of the block allocator.
interface spba_req_if;
	logic                           valid;
	logic                           ready;
	logic [spba_pkg::CMD_W-1:0]     cmd;
	logic [spba_pkg::SIZE_W-1:0]    req_size;
	logic [spba_pkg::ADDR_W-1:0]    block_addr;
	logic [spba_pkg::CIDX_W-1:0]    class_index;

	modport source (output valid, cmd, req_size, block_addr, class_index, input ready);
	modport sink (input valid, cmd, req_size, block_addr, class_index, output ready);
endinterface

interface spba_rsp_if;
	logic                           valid;
	logic                           ready;
	logic                           ok;
	logic [spba_pkg::ADDR_W-1:0]    block_offset;
	logic [spba_pkg::BYTES_W-1:0]   block_bytes;
	logic [spba_pkg::CCOUNT_W-1:0]  class_free_count;
	logic [spba_pkg::LIVE_W-1:0]    live_count;
	logic [spba_pkg::TOTAL_W-1:0]   alloc_total;
	logic [spba_pkg::FREEB_W-1:0]   free_bytes;

	modport source (output valid, ok, block_offset, block_bytes, class_free_count,
		live_count, alloc_total, free_bytes, input ready);
	modport sink (input valid, ok, block_offset, block_bytes, class_free_count,
		live_count, alloc_total, free_bytes, output ready);
endinterface

// ===== hdl/spba_ctrl.sv =====
// Sequencing state machine of the block allocator.
module spba_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  spba_pkg::dp_stat_t    stat,
	output spba_pkg::ctrl_cmd_t   cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_EX   = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	// One request is in flight at a time; a new beat is taken only when idle.
	assign req_ready = (state_q == ST_IDLE);

	// Next state and commands.
	always_comb begin
		state_nxt  = state_q;
		cmd.load   = 1'b0;
		cmd.rd     = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_RD;
				end
			end
			ST_RD: begin
				cmd.rd    = 1'b1;
				state_nxt = ST_EX;
			end
			ST_EX: begin
				// Hold the result until the response register can take it.
				if (!stat.rsp_stall) begin
					cmd.commit = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ===== hdl/spba_dp.sv =====
// Datapath of the block allocator: list registers, header store and response register.
module spba_dp #(
	parameter int MIN_POW     = 4,
	parameter int MAX_POW     = 12,
	parameter int CLASS_COUNT = 9,
	parameter int HEAP_BYTES  = 65536
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  spba_pkg::ctrl_cmd_t                cmd,
	output spba_pkg::dp_stat_t                 stat,
	input  logic                               cfg_we,
	input  logic [spba_pkg::CFG_W-1:0]         cfg_wdata,
	input  logic [spba_pkg::CMD_W-1:0]         in_cmd,
	input  logic [spba_pkg::SIZE_W-1:0]        in_req_size,
	input  logic [spba_pkg::ADDR_W-1:0]        in_block_addr,
	input  logic [spba_pkg::CIDX_W-1:0]        in_class_index,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               out_ok,
	output logic [spba_pkg::ADDR_W-1:0]        out_block_offset,
	output logic [spba_pkg::BYTES_W-1:0]       out_block_bytes,
	output logic [spba_pkg::CCOUNT_W-1:0]      out_class_free_count,
	output logic [spba_pkg::LIVE_W-1:0]        out_live_count,
	output logic [spba_pkg::TOTAL_W-1:0]       out_alloc_total,
	output logic [spba_pkg::FREEB_W-1:0]       out_free_bytes
);

	localparam int CW      = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
	localparam int HIW     = spba_pkg::HDR_IDX_W;
	localparam int NW      = spba_pkg::CNT_W;
	localparam int PW      = spba_pkg::POW_W;
	localparam int BW      = spba_pkg::CFG_W;
	localparam logic [BW-1:0] HEAP_LIM = BW'(HEAP_BYTES);
	localparam logic [NW-1:0] LIVE_MAX = {NW{1'b1}};

	// Configuration and allocator state.
	logic [BW-1:0]                    heap_size_q;
	logic [BW-1:0]                    bump_q;
	logic [HIW-1:0]                   head_q [CLASS_COUNT];
	logic [NW-1:0]                    count_q [CLASS_COUNT];
	logic [NW-1:0]                    live_q;
	logic [spba_pkg::TOTAL_W-1:0]     total_q;

	// Latched request.
	logic [spba_pkg::CMD_W-1:0]       cmd_q;
	logic [spba_pkg::SIZE_W-1:0]      size_q;
	logic [spba_pkg::ADDR_W-1:0]      addr_q;
	logic [spba_pkg::CIDX_W-1:0]      cidx_q;

	// Header store and its registered read data.
	logic [spba_pkg::CIDX_W-1:0]      hdr_cls_mem [spba_pkg::HDR_DEPTH];
	logic [HIW-1:0]                   hdr_link_mem [spba_pkg::HDR_DEPTH];
	logic [spba_pkg::CIDX_W-1:0]      hcls_rd_q;
	logic [HIW-1:0]                   hlink_rd_q;

	// Response register.
	logic                             rsp_valid_q;
	logic                             ok_q;
	logic [spba_pkg::ADDR_W-1:0]      offset_q;
	logic [spba_pkg::BYTES_W-1:0]     bytes_q;
	logic [spba_pkg::CCOUNT_W-1:0]    ccount_q;
	logic [spba_pkg::LIVE_W-1:0]      live_out_q;
	logic [spba_pkg::TOTAL_W-1:0]     total_out_q;
	logic [spba_pkg::FREEB_W-1:0]     freeb_q;

	// Working signals.
	logic [PW-1:0]                    pow_raw;
	logic [PW-1:0]                    pow_eff;
	logic [PW-1:0]                    a_cls;
	logic                             a_bad;
	logic [CW-1:0]                    a_idx;
	logic [HIW-1:0]                   a_head;
	logic                             a_pop;
	logic [BW:0]                      carve_next;
	logic                             carve_ok;
	logic                             a_ok;
	logic [HIW-1:0]                   a_hdr;
	logic [BW-1:0]                    heap_end;
	logic [HIW-1:0]                   f_hdr;
	logic [CW-1:0]                    f_idx;
	logic                             f_ok;
	logic [HIW-1:0]                   rd_addr;
	logic [PW-1:0]                    sz_shift;
	logic [31:0]                      sz_val;
	logic [CW-1:0]                    q_idx;
	logic                             ok_nxt;
	logic [spba_pkg::ADDR_W-1:0]      offset_nxt;
	logic [spba_pkg::BYTES_W-1:0]     bytes_nxt;
	logic [spba_pkg::CCOUNT_W-1:0]    ccount_nxt;
	logic [NW-1:0]                    live_nxt;
	logic [spba_pkg::TOTAL_W-1:0]     total_nxt;
	logic [BW-1:0]                    bump_nxt;
	logic                             do_pop;
	logic                             do_carve;
	logic                             do_push;

	assign stat.rsp_stall = rsp_valid_q && !out_ready;

	// Size class of an allocate request.
	always_comb begin
		pow_raw = spba_pkg::bit_len16(size_q - spba_pkg::SIZE_W'(1));
		pow_eff = (pow_raw < PW'(MIN_POW)) ? PW'(MIN_POW) : pow_raw;
		a_cls   = pow_eff - PW'(MIN_POW);
		a_bad   = (size_q == '0) || (pow_raw > PW'(MAX_POW)) ||
			(a_cls >= PW'(CLASS_COUNT));
		a_idx   = a_cls[CW-1:0];
		a_head  = a_bad ? '0 : head_q[a_idx];
		a_pop   = !a_bad && (count_q[a_idx] != '0);
	end

	// Bump carve check against the effective heap end.
	always_comb begin
		heap_end   = (heap_size_q > HEAP_LIM) ? HEAP_LIM : heap_size_q;
		carve_next = {1'b0, bump_q} + (BW+1)'((1 << pow_eff) + spba_pkg::HDR_BYTES);
		carve_ok   = carve_next < {1'b0, heap_end};
		a_ok       = !a_bad && (a_pop || carve_ok);
		a_hdr      = a_pop ? a_head : bump_q[spba_pkg::HDR_SHIFT +: HIW];
	end

	// Header index of a block address, and the class read back from it.
	always_comb begin
		f_hdr   = addr_q[spba_pkg::ADDR_W-1:spba_pkg::HDR_SHIFT] - HIW'(1);
		f_idx   = hcls_rd_q[CW-1:0];
		f_ok    = (addr_q != '0) && (hcls_rd_q < spba_pkg::CIDX_W'(CLASS_COUNT));
		rd_addr = (cmd_q == spba_pkg::CMD_ALLOC) ? a_head : f_hdr;
	end

	// Result and next state of the operation.
	always_comb begin
		q_idx      = cidx_q[CW-1:0];
		sz_shift   = PW'(MIN_POW) + PW'(hcls_rd_q);
		sz_val     = 32'd1 << sz_shift;
		ok_nxt     = 1'b0;
		offset_nxt = '0;
		bytes_nxt  = '0;
		ccount_nxt = '0;
		live_nxt   = live_q;
		total_nxt  = total_q;
		bump_nxt   = bump_q;
		do_pop     = 1'b0;
		do_carve   = 1'b0;
		do_push    = 1'b0;
		case (cmd_q)
			spba_pkg::CMD_ALLOC: begin
				if (a_ok) begin
					ok_nxt     = 1'b1;
					offset_nxt = {a_hdr, {spba_pkg::HDR_SHIFT{1'b0}}} +
						spba_pkg::ADDR_W'(spba_pkg::HDR_BYTES);
					live_nxt   = (live_q < LIVE_MAX) ? live_q + NW'(1) : live_q;
					total_nxt  = total_q + spba_pkg::TOTAL_W'(1);
					do_pop     = a_pop;
					do_carve   = !a_pop;
					if (!a_pop) begin
						bump_nxt = carve_next[BW-1:0];
					end
				end
			end
			spba_pkg::CMD_FREE: begin
				if (f_ok) begin
					ok_nxt   = 1'b1;
					do_push  = 1'b1;
					live_nxt = (live_q != '0) ? live_q - NW'(1) : live_q;
				end
			end
			spba_pkg::CMD_SIZE: begin
				if (f_ok) begin
					ok_nxt    = 1'b1;
					bytes_nxt = sz_val[spba_pkg::BYTES_W-1:0];
				end
			end
			spba_pkg::CMD_COUNT: begin
				ok_nxt = 1'b1;
				if (cidx_q < spba_pkg::CIDX_W'(CLASS_COUNT)) begin
					ccount_nxt = spba_pkg::CCOUNT_W'(count_q[q_idx]);
				end
			end
			default: begin
				ok_nxt = 1'b0;
			end
		endcase
	end

	// Request latch; no reset needed on payload.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q  <= in_cmd;
			size_q <= in_req_size;
			addr_q <= in_block_addr;
			cidx_q <= in_class_index;
		end
	end

	// Header store: registered read, one write per array on commit.
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			hcls_rd_q  <= hdr_cls_mem[rd_addr];
			hlink_rd_q <= hdr_link_mem[rd_addr];
		end
		if (cmd.commit && do_carve) begin
			hdr_cls_mem[a_hdr] <= a_cls[spba_pkg::CIDX_W-1:0];
		end
		if (cmd.commit && do_push) begin
			hdr_link_mem[f_hdr] <= head_q[f_idx];
		end
	end

	// Allocator state and configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_size_q <= spba_pkg::HEAP_SIZE_RST;
			bump_q      <= '0;
			live_q      <= '0;
			total_q     <= '0;
			for (int i = 0; i < CLASS_COUNT; i++) begin
				head_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				heap_size_q <= cfg_wdata;
			end
			if (cmd.commit) begin
				bump_q  <= bump_nxt;
				live_q  <= live_nxt;
				total_q <= total_nxt;
				if (do_pop) begin
					head_q[a_idx]  <= hlink_rd_q;
					count_q[a_idx] <= count_q[a_idx] - NW'(1);
				end
				if (do_push) begin
					head_q[f_idx]  <= f_hdr;
					count_q[f_idx] <= count_q[f_idx] + NW'(1);
				end
			end
		end
	end

	// Response valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (out_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Response payload, loaded with the state after the operation.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			ok_q        <= ok_nxt;
			offset_q    <= offset_nxt;
			bytes_q     <= bytes_nxt;
			ccount_q    <= ccount_nxt;
			live_out_q  <= spba_pkg::LIVE_W'(live_nxt);
			total_out_q <= total_nxt;
			freeb_q     <= (heap_end > bump_nxt) ? heap_end - bump_nxt : '0;
		end
	end

	assign out_valid            = rsp_valid_q;
	assign out_ok               = ok_q;
	assign out_block_offset     = offset_q;
	assign out_block_bytes      = bytes_q;
	assign out_class_free_count = ccount_q;
	assign out_live_count       = live_out_q;
	assign out_alloc_total      = total_out_q;
	assign out_free_bytes       = freeb_q;

endmodule

// ===== hdl/segregated_pow2_block_allocator.sv =====
// Top level of the segregated power-of-two block allocator.
// Requests arrive as beats on req: cmd selects allocate, free, block size query
// or class free count query; req_size, block_addr and class_index carry the
// operands. Every request gives exactly one response beat on rsp with the
// status, the allocated offset or queried value, and the live count, total
// allocation count and free heap bytes as they stand after the operation.
// The heap size register is written through cfg_we/cfg_wdata; the user must
// write it only while idle, which the block itself does not enforce.
// One request is worked on at a time: it is accepted, the header store is
// read in the next cycle, and the operation is then applied and the response
// register loaded once it can take the result; a new request is accepted
// only after the last one has loaded its response. The header store read is
// registered. A response waiting in the output register does not block
// acceptance of the next request; if the receiver stalls, that request holds
// in its final step until the response register frees up.
// Reset clears the bump pointer, free lists, counters and response valid, and
// sets the heap size to 65536; the header store is not cleared.
module segregated_pow2_block_allocator #(
	parameter int MIN_POW     = 4,
	parameter int MAX_POW     = 12,
	parameter int CLASS_COUNT = 9,
	parameter int HEAP_BYTES  = 65536
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [spba_pkg::CFG_W-1:0]  cfg_wdata,
	spba_req_if.sink                    req,
	spba_rsp_if.source                  rsp
);

	spba_pkg::ctrl_cmd_t  cmd;
	spba_pkg::dp_stat_t   stat;
	logic                 ready;

	assign req.ready = ready;

	// Sequencer.
	spba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Datapath.
	spba_dp #(
		.MIN_POW     (MIN_POW),
		.MAX_POW     (MAX_POW),
		.CLASS_COUNT (CLASS_COUNT),
		.HEAP_BYTES  (HEAP_BYTES)
	) u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cmd                  (cmd),
		.stat                 (stat),
		.cfg_we               (cfg_we),
		.cfg_wdata            (cfg_wdata),
		.in_cmd               (req.cmd),
		.in_req_size          (req.req_size),
		.in_block_addr        (req.block_addr),
		.in_class_index       (req.class_index),
		.out_valid            (rsp.valid),
		.out_ready            (rsp.ready),
		.out_ok               (rsp.ok),
		.out_block_offset     (rsp.block_offset),
		.out_block_bytes      (rsp.block_bytes),
		.out_class_free_count (rsp.class_free_count),
		.out_live_count       (rsp.live_count),
		.out_alloc_total      (rsp.alloc_total),
		.out_free_bytes       (rsp.free_bytes)
	);

endmodule
